FILE: src/swem_pkg.sv
`default_nettype none
package swem_pkg;

  localparam int STAMP_W    = 32;
  localparam int ERRCNT_W   = 11;
  localparam int LIMIT_W    = 11;
  localparam int WINDOW_W   = 16;
  localparam int TOTAL_W    = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(5);
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(10);

  // register select, taken from the word address bit
  typedef enum logic {
    REG_ERROR_LIMIT    = 1'b0,
    REG_WINDOW_SECONDS = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic               failed;
  } record_t;

endpackage
`default_nettype wire

FILE: src/swem_in_if.sv
`default_nettype none
interface swem_in_if;
  import swem_pkg::*;

  logic               valid;
  logic               ready;
  logic [STAMP_W-1:0] stamp_seconds;
  logic               failed;

  modport source (output valid, output stamp_seconds, output failed, input ready);
  modport sink   (input valid, input stamp_seconds, input failed, output ready);
endinterface
`default_nettype wire

FILE: src/swem_out_if.sv
`default_nettype none
interface swem_out_if;
  import swem_pkg::*;

  logic                valid;
  logic                ready;
  logic [ERRCNT_W-1:0] window_err_count;
  logic                tripped;
  logic [TOTAL_W-1:0]  operations_seen;
  logic [TOTAL_W-1:0]  errors_seen;

  modport source (output valid, output window_err_count, output tripped,
                  output operations_seen, output errors_seen, input ready);
  modport sink   (input valid, input window_err_count, input tripped,
                  input operations_seen, input errors_seen, output ready);
endinterface
`default_nettype wire

FILE: src/sliding_window_error_monitor.sv
`default_nettype none
// Channel   Dir  Handshake      Word
// ops       in   valid/ready    stamp_seconds[31:0], failed
// status    out  valid/ready    window_err_count[10:0], tripped,
//                               operations_seen[31:0], errors_seen[31:0]
// apb       in   psel/penable   error_limit @0x0, window_seconds @0x4, pready tied high
//
// Sequence: an ops word is taken in S_IDLE, then S_EVAL pops one expired record
//   per cycle; the single read port of the record RAM sets the pop rate.
// ops.ready is high only while the sequencer is idle.
// The status word sits in an output register; the next ops word is taken while
//   it waits, but a stalled status holds the sequencer in S_EVAL until it frees.
// Reset: synchronous; counters and pointers clear, the record RAM is not
//   cleared (only held records are ever read).
module sliding_window_error_monitor #(
  parameter int RING_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  swem_in_if.sink                         ops,
  swem_out_if.source                      status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [swem_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [swem_pkg::APB_DATA_W-1:0] pwdata,
  output logic [swem_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import swem_pkg::*;

  localparam int SLOT_W = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int WIDE_W = (CNT_W > ERRCNT_W) ? CNT_W : ERRCNT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL      = CNT_W'(RING_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_EVAL
  } state_t;

  state_t state;

  // config
  logic [LIMIT_W-1:0]  error_limit;
  logic [WINDOW_W-1:0] window_seconds;
  reg_sel_t            reg_sel;
  logic                cfg_write;

  // item being worked on
  logic [STAMP_W-1:0] now_stamp;
  logic               now_failed;
  logic               sweeping;

  // ring bookkeeping and totals
  logic [SLOT_W-1:0]  write_slot;
  logic [SLOT_W-1:0]  oldest_slot;
  logic [CNT_W-1:0]   records_held;
  logic [CNT_W-1:0]   window_errors;
  logic [TOTAL_W-1:0] total_ops;
  logic [TOTAL_W-1:0] total_errs;
  logic [STAMP_W-1:0] last_sweep_time;
  logic               trip_flag;

  logic                out_valid;
  logic [ERRCNT_W-1:0] out_errors;

  // RAM port
  record_t           rd_rec;
  record_t           wr_rec;
  logic [SLOT_W-1:0] raddr;
  logic              we;

  // shared subtractor and derived terms
  logic [STAMP_W-1:0] sub_a;
  logic [STAMP_W-1:0] sub_b;
  logic [STAMP_W-1:0] diff;
  logic               diff_pos;
  logic               expire;
  logic               out_free;
  logic               finish;
  logic               held_full;
  logic               pop_err;
  logic               drop_err;
  logic [SLOT_W-1:0]  oldest_inc;
  logic [SLOT_W-1:0]  write_inc;
  logic [CNT_W-1:0]   errs_after;
  logic               trip_after;

  // ---------------- config port ----------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = reg_sel_t'(paddr[2]);

  always_comb begin
    unique case (reg_sel)
      REG_ERROR_LIMIT:    prdata = APB_DATA_W'(error_limit);
      REG_WINDOW_SECONDS: prdata = APB_DATA_W'(window_seconds);
      default:            prdata = '0;
    endcase
  end

  // ---------------- datapath ----------------
  // One 32-bit subtractor: in idle it tests whether the stamp moved forward
  // since the last sweep; while evaluating it forms the age of the oldest record.
  assign sub_a    = (state == S_IDLE) ? ops.stamp_seconds : now_stamp;
  assign sub_b    = (state == S_IDLE) ? last_sweep_time : rd_rec.stamp;
  assign diff     = sub_a - sub_b;
  assign diff_pos = (diff != '0) && !diff[STAMP_W-1];

  // negative age (record from the future) never expires
  assign expire = (state == S_EVAL) && sweeping && (records_held != '0) &&
                  !diff[STAMP_W-1] && (diff[STAMP_W-2:0] > (STAMP_W-1)'(window_seconds));

  assign out_free  = !out_valid || status.ready;
  assign finish    = (state == S_EVAL) && !expire && out_free;
  assign held_full = (records_held == FULL);

  assign oldest_inc = (oldest_slot == LAST_SLOT) ? '0 : oldest_slot + 1'b1;
  assign write_inc  = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;

  // window count never goes below zero
  assign pop_err  = rd_rec.failed && (window_errors != '0);
  assign drop_err = held_full && pop_err;

  assign errs_after = window_errors - CNT_W'(drop_err) + CNT_W'(now_failed);
  assign trip_after = trip_flag || (WIDE_W'(errs_after) > WIDE_W'(error_limit));

  // RAM read data always holds the record at oldest_slot during S_EVAL:
  // on a pop the next oldest is fetched ahead.
  assign raddr = expire ? oldest_inc : oldest_slot;
  assign we    = finish;
  assign wr_rec.stamp  = now_stamp;
  assign wr_rec.failed = now_failed;

  swem_ram #(
    .WIDTH ($bits(record_t)),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (write_slot),
    .wdata (wr_rec),
    .raddr (raddr),
    .rdata (rd_rec)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      error_limit     <= LIMIT_RESET;
      window_seconds  <= WINDOW_RESET;
      write_slot      <= '0;
      oldest_slot     <= '0;
      records_held    <= '0;
      window_errors   <= '0;
      total_ops       <= '0;
      total_errs      <= '0;
      last_sweep_time <= '0;
      trip_flag       <= 1'b0;
      out_valid       <= 1'b0;
      sweeping        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (reg_sel)
          REG_ERROR_LIMIT:    error_limit    <= pwdata[LIMIT_W-1:0];
          REG_WINDOW_SECONDS: window_seconds <= pwdata[WINDOW_W-1:0];
          default: ;
        endcase
      end

      // a new word loads as the previous one leaves
      if (finish) begin
        out_valid <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (ops.valid) begin
            sweeping <= diff_pos;
            state    <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (expire) begin
            // pop one expired record
            oldest_slot   <= oldest_inc;
            records_held  <= records_held - 1'b1;
            window_errors <= window_errors - CNT_W'(pop_err);
          end else if (out_free) begin
            if (sweeping) begin
              last_sweep_time <= now_stamp;
            end
            // full ring: oldest leaves as the new record lands in its slot
            if (held_full) begin
              oldest_slot <= oldest_inc;
            end else begin
              records_held <= records_held + 1'b1;
            end
            write_slot    <= write_inc;
            window_errors <= errs_after;
            trip_flag     <= trip_after;
            if (total_ops != '1) begin
              total_ops <= total_ops + 1'b1;
            end
            if (now_failed && (total_errs != '1)) begin
              total_errs <= total_errs + 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (state == S_IDLE && ops.valid) begin
      now_stamp  <= ops.stamp_seconds;
      now_failed <= ops.failed;
    end
    if (finish) begin
      out_errors <= ERRCNT_W'(WIDE_W'(errs_after));
    end
  end

  // Totals and trip flag change only when a status word is loaded, so they
  // feed the port directly; the window count moves during the next sweep
  // and has its own output register.
  assign ops.ready               = (state == S_IDLE);
  assign status.valid            = out_valid;
  assign status.window_err_count = out_errors;
  assign status.tripped          = trip_flag;
  assign status.operations_seen  = total_ops;
  assign status.errors_seen      = total_errs;

  // ---------------- assertions ----------------
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    records_held <= FULL)
    else $error("record count above ring depth");

  a_errs_bound: assert property (@(posedge clk) disable iff (rst)
    window_errors <= records_held)
    else $error("window errors exceed held records");

  a_trip_sticky: assert property (@(posedge clk) disable iff (rst)
    trip_flag |=> trip_flag)
    else $error("trip flag cleared without reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (ops.valid && ops.ready) |=> !ops.ready)
    else $error("ops accepted while previous word in work");

endmodule
`default_nettype wire

FILE: src/swem_ram.sv
`default_nettype none
module swem_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: verif/swem_status_checker.sv
`timescale 1ns / 100ps
module swem_status_checker #(
  parameter int RING_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            op_valid,
  input  logic                            op_ready,
  input  logic [swem_pkg::STAMP_W-1:0]    op_stamp,
  input  logic                            op_failed,
  input  logic                            st_valid,
  input  logic                            st_ready,
  input  logic [swem_pkg::ERRCNT_W-1:0]   st_window_err_count,
  input  logic                            st_tripped,
  input  logic [swem_pkg::TOTAL_W-1:0]    st_operations_seen,
  input  logic [swem_pkg::TOTAL_W-1:0]    st_errors_seen,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [swem_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [swem_pkg::APB_DATA_W-1:0] pwdata,
  output int                              mismatch_count,
  output int                              status_owed
);
  import swem_pkg::*;

  typedef struct packed {
    logic [ERRCNT_W-1:0] in_window;
    logic                tripped;
    logic [TOTAL_W-1:0]  ops_total;
    logic [TOTAL_W-1:0]  errs_total;
  } status_word_t;

  // shadow of the record ring and counters
  logic [STAMP_W-1:0]  held_stamp [RING_DEPTH];
  logic                held_fail  [RING_DEPTH];
  int unsigned         oldest_idx;
  int unsigned         append_idx;
  int unsigned         held_count;
  logic [ERRCNT_W-1:0] window_errs;
  logic [TOTAL_W-1:0]  ops_total;
  logic [TOTAL_W-1:0]  errs_total;
  logic [STAMP_W-1:0]  last_sweep;
  logic                trip;
  logic [LIMIT_W-1:0]  limit_reg;
  logic [WINDOW_W-1:0] window_reg;
  status_word_t        status_owed_q [$];
  int                  word_count;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t ERROR status word %0d: %s got 0x%0h expected 0x%0h",
             $time, word_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic void retire_oldest();
    if (held_fail[oldest_idx] && window_errs != 0) window_errs--;
    oldest_idx = (oldest_idx + 1) % RING_DEPTH;
    held_count--;
  endfunction

  function automatic status_word_t account_op(input logic [STAMP_W-1:0] now,
                                              input logic fail);
    logic [STAMP_W-1:0] since;
    logic [STAMP_W-1:0] age;
    status_word_t       w;
    // sweep only when time moved forward (signed distance >= 1)
    since = now - last_sweep;
    if (since != 0 && !since[STAMP_W-1]) begin
      while (held_count != 0) begin
        age = now - held_stamp[oldest_idx];
        if (age[STAMP_W-1] || age <= window_reg) break;
        retire_oldest();
      end
      last_sweep = now;
    end
    if (held_count >= RING_DEPTH) retire_oldest();
    held_stamp[append_idx] = now;
    held_fail[append_idx]  = fail;
    append_idx = (append_idx + 1) % RING_DEPTH;
    held_count++;
    if (fail) begin
      window_errs++;
      if (errs_total != '1) errs_total++;
    end
    if (ops_total != '1) ops_total++;
    if (window_errs > limit_reg) trip = 1'b1;
    w.in_window  = window_errs;
    w.tripped    = trip;
    w.ops_total  = ops_total;
    w.errs_total = errs_total;
    return w;
  endfunction

  always @(posedge clk) begin : watch
    status_word_t got;
    status_word_t want;
    if (rst) begin
      oldest_idx     = 0;
      append_idx     = 0;
      held_count     = 0;
      window_errs    = '0;
      ops_total      = '0;
      errs_total     = '0;
      last_sweep     = '0;
      trip           = 1'b0;
      limit_reg      = LIMIT_RESET;
      window_reg     = WINDOW_RESET;
      word_count     = 0;
      mismatch_count = 0;
      status_owed_q.delete();
    end else begin
      if (st_valid && st_ready) begin
        got.in_window  = st_window_err_count;
        got.tripped    = st_tripped;
        got.ops_total  = st_operations_seen;
        got.errs_total = st_errors_seen;
        if (status_owed_q.size() == 0) begin
          report("word with none owed", 32'd1, 32'd0);
        end else begin
          want = status_owed_q.pop_front();
          if (got.in_window !== want.in_window)
            report("window_err_count", 32'(got.in_window), 32'(want.in_window));
          if (got.tripped !== want.tripped)
            report("tripped", 32'(got.tripped), 32'(want.tripped));
          if (got.ops_total !== want.ops_total)
            report("operations_seen", got.ops_total, want.ops_total);
          if (got.errs_total !== want.errs_total)
            report("errors_seen", got.errs_total, want.errs_total);
        end
        word_count++;
      end
      if (op_valid && op_ready) status_owed_q.push_back(account_op(op_stamp, op_failed));
      if (psel && penable && pwrite && pready) begin
        case (reg_sel_t'(paddr[2]))
          REG_ERROR_LIMIT:    limit_reg  = pwdata[LIMIT_W-1:0];
          REG_WINDOW_SECONDS: window_reg = pwdata[WINDOW_W-1:0];
          default: ;
        endcase
      end
    end
    status_owed = status_owed_q.size();
  end

endmodule

FILE: verif/tb_sliding_window_error_monitor.sv
`timescale 1ns / 100ps
module tb_sliding_window_error_monitor;
  import swem_pkg::*;

  localparam int RING_DEPTH  = 1024;
  // worst case is far below this: ~1800 words with their stalls, and
  // every record pushed and swept out at most once
  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int                    send_idle_pct;
  int                    recv_idle_pct;
  int                    mismatch_count;
  int                    status_owed;
  int                    cycle_count;
  // running time base for random stamps; noise words stray from it
  logic [STAMP_W-1:0]    clock_now;

  swem_in_if  ops_ch ();
  swem_out_if status_ch ();

  sliding_window_error_monitor #(.RING_DEPTH(RING_DEPTH)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .ops     (ops_ch.sink),
    .status  (status_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // the checker watches ops, status and the register port on its own
  swem_status_checker #(.RING_DEPTH(RING_DEPTH)) u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .op_valid            (ops_ch.valid),
    .op_ready            (ops_ch.ready),
    .op_stamp            (ops_ch.stamp_seconds),
    .op_failed           (ops_ch.failed),
    .st_valid            (status_ch.valid),
    .st_ready            (status_ch.ready),
    .st_window_err_count (status_ch.window_err_count),
    .st_tripped          (status_ch.tripped),
    .st_operations_seen  (status_ch.operations_seen),
    .st_errors_seen      (status_ch.errors_seen),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .pready              (pready),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .mismatch_count      (mismatch_count),
    .status_owed         (status_owed)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // status back-pressure: a fresh coin every cycle
  always @(negedge clk) begin
    status_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Offer one ops word; valid stays high on return so that back-to-back
  // words never lower and raise valid in the same step.
  task automatic send_op(input logic [STAMP_W-1:0] stamp, input logic fail);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      ops_ch.valid <= 1'b0;
      @(negedge clk);
    end
    ops_ch.valid         <= 1'b1;
    ops_ch.stamp_seconds <= stamp;
    ops_ch.failed        <= fail;
    do @(posedge clk); while (!ops_ch.ready);
    @(negedge clk);
  endtask

  // Stop offering, wait for every status word, then let the sequencer settle
  // before touching the registers.
  task automatic drain();
    ops_ch.valid <= 1'b0;
    while (status_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Both registers in one burst: psel stays high across the two transfers.
  task automatic program_regs(input logic [LIMIT_W-1:0] limit,
                              input logic [WINDOW_W-1:0] window);
    reg_sel_t sel;
    for (int i = 0; i < 2; i++) begin
      sel = reg_sel_t'(i[0]);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {sel, 2'b00};
      pwdata  <= (sel == REG_ERROR_LIMIT) ? APB_DATA_W'(limit) : APB_DATA_W'(window);
      @(negedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      @(negedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly a slowly advancing clock. Calm mode only creeps forward or steps
  // back a little, so nothing ages out of a wide window and the ring fills.
  // Otherwise: repeats, backward stamps, short and long jumps, absolute
  // random stamps, and stamps near half the modulus where the signed
  // distance flips.
  function automatic logic [STAMP_W-1:0] random_stamp(input bit calm);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm) begin
      if (pick < 92) begin
        clock_now += $urandom_range(0, 20);
        return clock_now;
      end
      return clock_now - $urandom_range(1, 40);
    end
    if (pick < 60) clock_now += $urandom_range(0, 3);
    else if (pick < 75) ;
    else if (pick < 85) return clock_now - $urandom_range(1, 50);
    else if (pick < 93) clock_now += $urandom_range(5, 200);
    else if (pick < 97) clock_now = $urandom();
    else return clock_now + 32'h8000_0000 + $urandom_range(0, 2) - 1;
    return clock_now;
  endfunction

  initial begin
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    ops_ch.valid         = 1'b0;
    ops_ch.stamp_seconds = '0;
    ops_ch.failed        = 1'b0;
    status_ch.ready      = 1'b0;
    clock_now            = '0;
    send_idle_pct        = 11;
    recv_idle_pct        = 46;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words at reset settings (limit 5, window 10).
    // Stamp equal to the reset sweep time: no sweep.
    send_op(32'd0, 1'b0);
    send_op(32'd0, 1'b1);
    // errors pile up inside the window; the seventh word trips
    send_op(32'd3, 1'b1);
    send_op(32'd5, 1'b1);
    send_op(32'd8, 1'b1);
    send_op(32'd10, 1'b1);
    send_op(32'd10, 1'b1);
    // age 11 > 10: both stamp-0 records drop, one of them an error
    send_op(32'd11, 1'b1);
    // everything ages out at once
    send_op(32'd30, 1'b0);
    // backward stamp, then one equal to the last sweep time
    send_op(32'd20, 1'b1);
    send_op(32'd30, 1'b0);
    // record from the future: pushed without a sweep since the signed
    // distance is negative, then it blocks the sweep at 215 once it is oldest
    send_op(32'd200, 1'b1);
    send_op(32'h8000_00D0, 1'b1);
    send_op(32'd215, 1'b0);
    send_op(32'd216, 1'b0);
    // forward just over half the modulus: the signed distance is negative, so no sweep runs and the future record stays
    send_op(32'h8000_1000, 1'b0);
    // wrap through the top of the stamp range
    send_op(32'hFFFF_FFF8, 1'b1);
    send_op(32'hFFFF_FFFF, 1'b1);
    send_op(32'h0000_0004, 1'b0);
    drain();

    // Low extremes: window 0 expires anything older than now, limit 0.
    program_regs(LIMIT_W'(0), WINDOW_W'(0));
    clock_now = $urandom();
    repeat (450) send_op(random_stamp(1'b0), ($urandom_range(0, 99) < 40));
    drain();

    // High extremes with the idle rates swapped; the ring fills and the
    // oldest record is evicted on every append from then on.
    send_idle_pct = 46;
    recv_idle_pct = 11;
    program_regs(LIMIT_W'(1024), WINDOW_W'(16'hFFFF));
    repeat (1150) send_op(random_stamp(1'b1), ($urandom_range(0, 99) < 50));
    drain();

    // Random settings, no idling. The first word jumps past the old window so
    // one sweep empties a full ring.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(LIMIT_W'($urandom_range(0, 1024)), WINDOW_W'($urandom_range(1, 60)));
    clock_now = clock_now + 32'd70000;
    send_op(clock_now, 1'b1);
    repeat (150) send_op(random_stamp(1'b0), ($urandom_range(0, 99) < 30));
    drain();

    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t ERROR timeout after %0d cycles, %0d status words owed",
             $time, cycle_count, status_owed);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
src/swem_pkg.sv
src/swem_in_if.sv
src/swem_out_if.sv
src/swem_ram.sv
src/sliding_window_error_monitor.sv
verif/swem_status_checker.sv
verif/tb_sliding_window_error_monitor.sv
